// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a consequence in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a consequence a fixed number of cycles later
`define ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
		else $error(msg);

`endif

// ----- rtl/sge_pkg.sv -----
`default_nettype none

package sge_pkg;

	localparam int DIV_W              = 16;
	localparam int B_W                = 5;
	localparam int VALUE_BITS_DEF     = 16;
	localparam int MAX_CODE_BITS_DEF  = 64;
	localparam logic [DIV_W-1:0] DIVISOR_RESET = 16'd4;

	typedef struct packed {
		logic [DIV_W-1:0] m;
		logic [B_W-1:0]   b;
		logic             pow2;
		logic [DIV_W-1:0] u;
		logic             zero;
	} div_info_t;

	function automatic div_info_t div_info(input logic [DIV_W-1:0] m);
		div_info_t        info;
		logic [DIV_W-1:0] mm1;
		logic [DIV_W:0]   span;
		mm1    = m - 1'b1;
		info.m = m;
		info.b = '0;
		for (int i = 0; i < DIV_W; i++) begin
			if (mm1[i]) begin
				info.b = B_W'(i + 1);
			end
		end
		info.zero = (m == '0);
		info.pow2 = ((m & mm1) == '0);
		span      = (DIV_W+1)'(1) << info.b;
		span      = span - {1'b0, m};
		info.u    = span[DIV_W-1:0];
		return info;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/sge_cell.sv -----
`default_nettype none
`include "assert_macros.svh"

module sge_cell #(
	parameter int VALUE_BITS = sge_pkg::VALUE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [sge_pkg::DIV_W-1:0]    m,
	input  wire logic                         vld_in,
	input  wire logic [sge_pkg::DIV_W-1:0]    rem_in,
	input  wire logic [VALUE_BITS-1:0]        word_in,
	output logic                              vld_out,
	output logic [sge_pkg::DIV_W-1:0]         rem_out,
	output logic [VALUE_BITS-1:0]             word_out
);

	logic [sge_pkg::DIV_W:0]   trial;
	logic [sge_pkg::DIV_W:0]   diff;
	logic                      ge;
	logic [sge_pkg::DIV_W-1:0] rem_n;
	logic [VALUE_BITS-1:0]     word_n;

	logic                      vld_s1;
	logic [sge_pkg::DIV_W-1:0] rem_s1;
	logic [VALUE_BITS-1:0]     word_s1;

	// one restoring step: bring in the next index bit, shift the quotient bit in
	always_comb begin
		trial  = {rem_in, word_in[VALUE_BITS-1]};
		diff   = trial - {1'b0, m};
		ge     = (trial >= {1'b0, m});
		rem_n  = ge ? diff[sge_pkg::DIV_W-1:0] : trial[sge_pkg::DIV_W-1:0];
		word_n = {word_in[VALUE_BITS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_s1  <= rem_n;
		word_s1 <= word_n;
	end

	assign vld_out  = vld_s1;
	assign rem_out  = rem_s1;
	assign word_out = word_s1;

	`ASSERT_IMPL(a_rem_below_divisor, clk, arst_n, vld_s1 && (m != '0), rem_s1 < m, "partial remainder not below divisor")

endmodule

`default_nettype wire

// ----- rtl/sge_tail.sv -----
`default_nettype none
`include "assert_macros.svh"

module sge_tail #(
	parameter int VALUE_BITS    = sge_pkg::VALUE_BITS_DEF,
	parameter int MAX_CODE_BITS = sge_pkg::MAX_CODE_BITS_DEF,
	localparam int LEN_W        = $clog2(MAX_CODE_BITS + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sge_pkg::div_info_t            info,
	input  wire logic                          vld_in,
	input  wire logic [VALUE_BITS-1:0]         quot,
	input  wire logic [sge_pkg::DIV_W-1:0]     rem,
	output logic                               done,
	output logic [MAX_CODE_BITS-1:0]           code_bits,
	output logic [LEN_W-1:0]                   code_length,
	output logic                               too_long
);

	localparam int SUM_W = $clog2(MAX_CODE_BITS + 18);

	logic                      r_lt_u;
	logic                      sel_hi;
	logic [sge_pkg::B_W-1:0]   rb;
	logic [sge_pkg::DIV_W-1:0] remv;
	logic                      q_big;
	logic [SUM_W-1:0]          len;
	logic                      long_d;

	logic                      vld_s1;
	logic                      long_s1;
	logic [SUM_W-1:0]          len_s1;
	logic [sge_pkg::B_W-1:0]   rb_s1;
	logic [sge_pkg::DIV_W-1:0] remv_s1;

	logic [MAX_CODE_BITS-1:0]  rem_ext;
	logic [MAX_CODE_BITS-1:0]  code;

	logic                      done_s2;
	logic                      long_s2;
	logic [MAX_CODE_BITS-1:0]  code_s2;
	logic [LEN_W-1:0]          len_s2;

	// truncated binary remainder and codeword length
	always_comb begin
		r_lt_u = (rem < info.u);
		sel_hi = !info.pow2 && !r_lt_u;
		rb     = (info.pow2 || sel_hi) ? info.b : info.b - 1'b1;
		remv   = sel_hi ? rem + info.u : rem;
		q_big  = (32'(quot) >= 32'(MAX_CODE_BITS));
		len    = SUM_W'(quot) + SUM_W'(1) + SUM_W'(rb);
		long_d = info.zero || q_big || (len > SUM_W'(MAX_CODE_BITS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			vld_s1  <= vld_in;
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		long_s1 <= long_d;
		len_s1  <= len;
		rb_s1   <= rb;
		remv_s1 <= remv;
	end

	// unary ones sit between the remainder field and the code length
	always_comb begin
		rem_ext = MAX_CODE_BITS'(remv_s1);
		for (int i = 0; i < MAX_CODE_BITS; i++) begin
			code[i] = rem_ext[i] | ((i > int'(rb_s1)) && (i < int'(len_s1)));
		end
	end

	always_ff @(posedge clk) begin
		long_s2 <= long_s1;
		code_s2 <= long_s1 ? '0 : code;
		len_s2  <= long_s1 ? '0 : len_s1[LEN_W-1:0];
	end

	assign done        = done_s2;
	assign code_bits   = code_s2;
	assign code_length = len_s2;
	assign too_long    = long_s2;

	`ASSERT_IMPL(a_long_stage_len, clk, arst_n, vld_s1 && !long_s1, (len_s1 != '0) && (len_s1 <= SUM_W'(MAX_CODE_BITS)), "codeword length out of range")

endmodule

`default_nettype wire

// ----- rtl/signed_golomb_encoder.sv -----
// Channel    Handshake          Payload
// ---------  -----------------  ------------------------------------------
// input      start, busy        value
// result     done               code_bits, code_length, too_long
// divisor    divisor_we         divisor_wdata
//
// A transaction is taken on every cycle with start high; busy stays low.
// Results pass through one registered divider cell per index bit, then a
// remainder stage and a codeword stage.
// Reset (arst_n low) clears all valid flags and loads divisor 4.
// The receiver cannot stall; done is a single-cycle strobe.
`default_nettype none
`include "assert_macros.svh"

module signed_golomb_encoder #(
	parameter int VALUE_BITS    = sge_pkg::VALUE_BITS_DEF,
	parameter int MAX_CODE_BITS = sge_pkg::MAX_CODE_BITS_DEF,
	localparam int LEN_W        = $clog2(MAX_CODE_BITS + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [VALUE_BITS-1:0]  value,
	output logic                               done,
	output logic [MAX_CODE_BITS-1:0]           code_bits,
	output logic [LEN_W-1:0]                   code_length,
	output logic                               too_long,
	input  wire logic                          divisor_we,
	input  wire logic [sge_pkg::DIV_W-1:0]     divisor_wdata
);

	localparam int LAT = VALUE_BITS + 2;

	sge_pkg::div_info_t          info_q;
	logic [VALUE_BITS-1:0]       folded;

	logic                        vld_c  [0:VALUE_BITS];
	logic [sge_pkg::DIV_W-1:0]   rem_c  [0:VALUE_BITS];
	logic [VALUE_BITS-1:0]       word_c [0:VALUE_BITS];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_q <= sge_pkg::div_info(sge_pkg::DIVISOR_RESET);
		end else if (divisor_we) begin
			info_q <= sge_pkg::div_info(divisor_wdata);
		end
	end

	// zigzag fold
	assign folded = {value[VALUE_BITS-2:0], 1'b0} ^ {VALUE_BITS{value[VALUE_BITS-1]}};

	assign vld_c[0]  = start && !busy;
	assign rem_c[0]  = '0;
	assign word_c[0] = folded;

	for (genvar g = 0; g < VALUE_BITS; g++) begin : g_cell
		sge_cell #(
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.m        (info_q.m),
			.vld_in   (vld_c[g]),
			.rem_in   (rem_c[g]),
			.word_in  (word_c[g]),
			.vld_out  (vld_c[g+1]),
			.rem_out  (rem_c[g+1]),
			.word_out (word_c[g+1])
		);
	end

	sge_tail #(
		.VALUE_BITS    (VALUE_BITS),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_tail (
		.clk         (clk),
		.arst_n      (arst_n),
		.info        (info_q),
		.vld_in      (vld_c[VALUE_BITS]),
		.quot        (word_c[VALUE_BITS]),
		.rem         (rem_c[VALUE_BITS]),
		.done        (done),
		.code_bits   (code_bits),
		.code_length (code_length),
		.too_long    (too_long)
	);

	`ASSERT_IMPL(a_flag_vs_length, clk, arst_n, done, too_long == (code_length == '0), "too_long disagrees with code_length")
	`ASSERT_DELAY(a_latency, clk, arst_n, start && !busy, LAT, done, "result missing after fixed latency")
	`ASSERT_IMPL(a_no_spurious, clk, arst_n, done, $past(start && !busy, LAT), "result without a matching transaction")

endmodule

`default_nettype wire
